### rtl/imm_pkg.sv
package imm_pkg;

  localparam int MAX_DIM    = 8;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = $clog2(MAX_DIM);
  localparam int ADDR_W     = 2 * IDX_W;
  localparam int DIM_W      = 4;
  localparam int CMD_W      = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int STEP_W     = 3;
  localparam int JC_W       = 3;

  // commands
  localparam logic [CMD_W-1:0] CMD_LOAD_A = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD_B = 2'd1;
  localparam logic [CMD_W-1:0] CMD_MUL    = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROWS_A = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_A = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS_B = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_B = 2'd3;

  // microprogram steps
  localparam logic [STEP_W-1:0] S_IDLE  = 3'd0;
  localparam logic [STEP_W-1:0] S_CHECK = 3'd1;
  localparam logic [STEP_W-1:0] S_READ  = 3'd2;
  localparam logic [STEP_W-1:0] S_MUL   = 3'd3;
  localparam logic [STEP_W-1:0] S_ACC   = 3'd4;
  localparam logic [STEP_W-1:0] S_EMIT  = 3'd5;
  localparam logic [STEP_W-1:0] S_DONE  = 3'd6;
  localparam logic [STEP_W-1:0] S_ERR   = 3'd7;

  // jump conditions: jump to target when true, else fall through
  localparam logic [JC_W-1:0] J_NEXT    = 3'd0;
  localparam logic [JC_W-1:0] J_ALWAYS  = 3'd1;
  localparam logic [JC_W-1:0] J_NOT_MUL = 3'd2;
  localparam logic [JC_W-1:0] J_DIM_BAD = 3'd3;
  localparam logic [JC_W-1:0] J_K_MORE  = 3'd4;
  localparam logic [JC_W-1:0] J_MORE    = 3'd5;

  typedef struct packed {
    logic in_rdy;
    logic clr;
    logic rd;
    logic mul;
    logic acc;
    logic emit;
    logic err;
  } ops_t;

  typedef struct packed {
    ops_t              ops;
    logic [JC_W-1:0]   jcond;
    logic [STEP_W-1:0] target;
  } ucw_t;

  typedef struct packed {
    ops_t ops;
    logic adv;
  } ctrl_t;

  typedef struct packed {
    logic mul_beat;
    logic dim_bad;
    logic k_more;
    logic more;
    logic slot_free;
  } stat_t;

  function automatic ucw_t ucode(input logic [STEP_W-1:0] pc);
    ucw_t w;
    w = '0;
    case (pc)
      S_IDLE: begin
        w.ops.in_rdy = 1'b1;
        w.jcond      = J_NOT_MUL;
        w.target     = S_IDLE;
      end
      S_CHECK: begin
        w.ops.clr = 1'b1;
        w.jcond   = J_DIM_BAD;
        w.target  = S_ERR;
      end
      S_READ:  w.ops.rd = 1'b1;
      S_MUL:   w.ops.mul = 1'b1;
      S_ACC: begin
        w.ops.acc = 1'b1;
        w.jcond   = J_K_MORE;
        w.target  = S_READ;
      end
      S_EMIT: begin
        w.ops.emit = 1'b1;
        w.jcond    = J_MORE;
        w.target   = S_READ;
      end
      S_DONE: begin
        w.jcond  = J_ALWAYS;
        w.target = S_IDLE;
      end
      S_ERR: begin
        w.ops.err = 1'b1;
        w.jcond   = J_ALWAYS;
        w.target  = S_IDLE;
      end
      default: w = '0;
    endcase
    return w;
  endfunction

  // zero counts as one, anything above MAX_DIM as MAX_DIM; returns size - 1
  function automatic logic [IDX_W-1:0] eff_dim_m1(input logic [DIM_W-1:0] d);
    logic [IDX_W-1:0] r;
    if (d == '0) begin
      r = '0;
    end else if (d > DIM_W'(MAX_DIM)) begin
      r = IDX_W'(MAX_DIM - 1);
    end else begin
      r = IDX_W'(d - 1'b1);
    end
    return r;
  endfunction

endpackage

### rtl/imm_if.sv
interface imm_in_if;
  logic                                     valid;
  logic                                     ready;
  logic [imm_pkg::CMD_W-1:0]                cmd;
  logic [imm_pkg::IDX_W-1:0]                row;
  logic [imm_pkg::IDX_W-1:0]                col;
  logic signed [imm_pkg::DATA_WIDTH-1:0]    value;

  modport source (output valid, cmd, row, col, value, input ready);
  modport sink   (input valid, cmd, row, col, value, output ready);
endinterface

interface imm_out_if;
  logic                                     valid;
  logic                                     ready;
  logic [imm_pkg::IDX_W-1:0]                out_row;
  logic [imm_pkg::IDX_W-1:0]                out_col;
  logic signed [imm_pkg::DATA_WIDTH-1:0]    product;
  logic                                     last;
  logic                                     dim_error;

  modport source (output valid, out_row, out_col, product, last, dim_error, input ready);
  modport sink   (input valid, out_row, out_col, product, last, dim_error, output ready);
endinterface

### rtl/imm_seq.sv
module imm_seq (
  input  logic           clk,
  input  logic           rst_n,
  input  imm_pkg::stat_t stat,
  output imm_pkg::ctrl_t ctrl
);

  logic [imm_pkg::STEP_W-1:0] pc_r;
  logic [imm_pkg::STEP_W-1:0] pc_nxt;
  imm_pkg::ucw_t              cw;
  logic                       hold;
  logic                       take;

  assign cw = imm_pkg::ucode(pc_r);

  // result steps wait for the output slot
  assign hold = (cw.ops.emit || cw.ops.err) && !stat.slot_free;

  always_comb begin
    case (cw.jcond)
      imm_pkg::J_NEXT:    take = 1'b0;
      imm_pkg::J_ALWAYS:  take = 1'b1;
      imm_pkg::J_NOT_MUL: take = !stat.mul_beat;
      imm_pkg::J_DIM_BAD: take = stat.dim_bad;
      imm_pkg::J_K_MORE:  take = stat.k_more;
      imm_pkg::J_MORE:    take = stat.more;
      default:            take = 1'b0;
    endcase
    if (hold) begin
      pc_nxt = pc_r;
    end else if (take) begin
      pc_nxt = cw.target;
    end else begin
      pc_nxt = pc_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= imm_pkg::S_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  assign ctrl.ops = cw.ops;
  assign ctrl.adv = !hold;

endmodule

### rtl/integer_matrix_multiply.sv
// Channel  Dir  Beat carries                                  Handshake
// in_ch    in   cmd, row, col, value                          valid/ready
// out_ch   out  out_row, out_col, product, last, dim_error    valid/ready
// cfg_*    in   cfg_index, cfg_data                           cfg_we, no wait
//
// Loads may follow each other every cycle.
// A multiply holds ready low while one MAC unit walks the inner products, each
// term costing a store read, a multiply and an add. A dimension mismatch sends
// the sequencer from the check step to the error step. A stalled output slot
// holds the sequencer on the result step. Synchronous reset sets all dimensions
// to 8; stores are not cleared.
module integer_matrix_multiply (
  input  logic                                clk,
  input  logic                                rst_n,
  imm_in_if.sink                              in_ch,
  imm_out_if.source                           out_ch,
  input  logic                                cfg_we,
  input  logic [imm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [imm_pkg::DIM_W-1:0]           cfg_data
);

  localparam int DW = imm_pkg::DATA_WIDTH;
  localparam int IW = imm_pkg::IDX_W;

  logic [imm_pkg::DIM_W-1:0] rows_a_r, cols_a_r, rows_b_r, cols_b_r;
  logic [IW-1:0]             ra_m1, ca_m1, rb_m1, cb_m1;

  logic [DW-1:0] store_a [imm_pkg::MAX_DIM*imm_pkg::MAX_DIM];
  logic [DW-1:0] store_b [imm_pkg::MAX_DIM*imm_pkg::MAX_DIM];

  logic [DW-1:0]   a_r, b_r, prod_r, acc_r;
  logic [DW-1:0]   mul_low;
  logic [IW-1:0]   i_r, j_r, k_r;

  logic          out_valid_r;
  logic [IW-1:0] out_row_r, out_col_r;
  logic [DW-1:0] out_product_r;
  logic          out_last_r, out_dim_error_r;

  imm_pkg::ctrl_t ctrl;
  imm_pkg::stat_t stat;

  logic in_beat, load_a, load_b, emit_fire, err_fire, last_elem, slot_free;

  assign ra_m1 = imm_pkg::eff_dim_m1(rows_a_r);
  assign ca_m1 = imm_pkg::eff_dim_m1(cols_a_r);
  assign rb_m1 = imm_pkg::eff_dim_m1(rows_b_r);
  assign cb_m1 = imm_pkg::eff_dim_m1(cols_b_r);

  assign in_ch.ready = ctrl.ops.in_rdy;
  assign in_beat     = in_ch.valid && in_ch.ready;
  assign load_a      = in_beat && (in_ch.cmd == imm_pkg::CMD_LOAD_A);
  assign load_b      = in_beat && (in_ch.cmd == imm_pkg::CMD_LOAD_B);

  assign slot_free = !out_valid_r || out_ch.ready;
  assign last_elem = (i_r == ra_m1) && (j_r == cb_m1);
  assign emit_fire = ctrl.ops.emit && ctrl.adv;
  assign err_fire  = ctrl.ops.err && ctrl.adv;

  assign stat.mul_beat  = in_beat && (in_ch.cmd == imm_pkg::CMD_MUL);
  assign stat.dim_bad   = (ca_m1 != rb_m1);
  assign stat.k_more    = (k_r != ca_m1);
  assign stat.more      = !last_elem;
  assign stat.slot_free = slot_free;

  imm_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  // element stores: one write port from the input, one registered read port
  always_ff @(posedge clk) begin
    if (load_a) begin
      store_a[{in_ch.row, in_ch.col}] <= in_ch.value;
    end
    if (load_b) begin
      store_b[{in_ch.row, in_ch.col}] <= in_ch.value;
    end
    if (ctrl.ops.rd) begin
      a_r <= store_a[{i_r, k_r}];
      b_r <= store_b[{k_r, j_r}];
    end
  end

  // low half of the product is the same for signed and unsigned operands
  assign mul_low = a_r * b_r;

  always_ff @(posedge clk) begin
    if (ctrl.ops.mul) begin
      prod_r <= mul_low;
    end
    if (ctrl.ops.clr || emit_fire) begin
      acc_r <= '0;
    end else if (ctrl.ops.acc) begin
      acc_r <= acc_r + prod_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_a_r <= imm_pkg::DIM_W'(imm_pkg::MAX_DIM);
      cols_a_r <= imm_pkg::DIM_W'(imm_pkg::MAX_DIM);
      rows_b_r <= imm_pkg::DIM_W'(imm_pkg::MAX_DIM);
      cols_b_r <= imm_pkg::DIM_W'(imm_pkg::MAX_DIM);
      i_r      <= '0;
      j_r      <= '0;
      k_r      <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          imm_pkg::REG_ROWS_A: rows_a_r <= cfg_data;
          imm_pkg::REG_COLS_A: cols_a_r <= cfg_data;
          imm_pkg::REG_ROWS_B: rows_b_r <= cfg_data;
          imm_pkg::REG_COLS_B: cols_b_r <= cfg_data;
          default: ;
        endcase
      end
      if (ctrl.ops.clr) begin
        i_r <= '0;
        j_r <= '0;
        k_r <= '0;
      end
      if (ctrl.ops.acc && stat.k_more) begin
        k_r <= k_r + 1'b1;
      end
      if (emit_fire) begin
        k_r <= '0;
        if (j_r == cb_m1) begin
          j_r <= '0;
          i_r <= i_r + 1'b1;
        end else begin
          j_r <= j_r + 1'b1;
        end
      end
    end
  end

  // output slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_fire || err_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      out_row_r       <= i_r;
      out_col_r       <= j_r;
      out_product_r   <= acc_r;
      out_last_r      <= last_elem;
      out_dim_error_r <= 1'b0;
    end else if (err_fire) begin
      out_row_r       <= '0;
      out_col_r       <= '0;
      out_product_r   <= '0;
      out_last_r      <= 1'b1;
      out_dim_error_r <= 1'b1;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_row   = out_row_r;
  assign out_ch.out_col   = out_col_r;
  assign out_ch.product   = out_product_r;
  assign out_ch.last      = out_last_r;
  assign out_ch.dim_error = out_dim_error_r;

  // no inner-product walk is under way while input beats are taken
  a_idle_k: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> (k_r == '0))
    else $error("inner index not reset while accepting input");

  // an error beat is always final and carries no product
  a_err_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_dim_error_r) |-> (out_last_r && (out_product_r == '0)))
    else $error("malformed dimension error beat");

  // store read is always followed by the multiply step
  a_rd_mul: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.ops.rd |=> ctrl.ops.mul)
    else $error("read step not followed by multiply");

  a_rdy_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctrl.ops.in_rdy && (ctrl.ops.emit || ctrl.ops.err)))
    else $error("input accepted during a result step");

endmodule

### bench/integer_matrix_multiply_tb.sv
`timescale 1ns / 1ps

module integer_matrix_multiply_tb;

  localparam int MAX_DIM    = imm_pkg::MAX_DIM;
  localparam int DATA_WIDTH = imm_pkg::DATA_WIDTH;
  localparam int IDX_W      = imm_pkg::IDX_W;
  localparam int DIM_W      = imm_pkg::DIM_W;
  localparam int CMD_W      = imm_pkg::CMD_W;
  localparam int CFG_IDX_W  = imm_pkg::CFG_IDX_W;

  localparam logic [CMD_W-1:0]     CMD_LOAD_A = imm_pkg::CMD_LOAD_A;
  localparam logic [CMD_W-1:0]     CMD_LOAD_B = imm_pkg::CMD_LOAD_B;
  localparam logic [CMD_W-1:0]     CMD_MUL    = imm_pkg::CMD_MUL;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS_A = imm_pkg::REG_ROWS_A;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_A = imm_pkg::REG_COLS_A;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS_B = imm_pkg::REG_ROWS_B;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_B = imm_pkg::REG_COLS_B;

  localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;
  localparam int IDLE_PCT      = 21;
  localparam int SETTLE_CYCLES = 4;
  localparam int RANDOM_ITEMS  = 100;
  localparam int HOLD_CYCLES   = 400;
  localparam int CELLS         = MAX_DIM * MAX_DIM;

  typedef struct packed {
    logic [IDX_W-1:0]             r;
    logic [IDX_W-1:0]             c;
    logic signed [DATA_WIDTH-1:0] product;
    logic                         last;
    logic                         dim_error;
  } elem_t;

  typedef enum logic {ROW_REG, ROW_BEAT} row_kind_t;

  typedef struct {
    row_kind_t                    kind;
    logic [CFG_IDX_W-1:0]         idx;
    logic [DIM_W-1:0]             data;
    logic [CMD_W-1:0]             cmd;
    logic [IDX_W-1:0]             r;
    logic [IDX_W-1:0]             c;
    logic signed [DATA_WIDTH-1:0] v;
    bit                           typed;
    logic signed [DATA_WIDTH-1:0] want;
    bit                           want_err;
  } plan_row_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DIM_W-1:0]     cfg_data;
  logic                 rx_ready = 1'b0;

  imm_in_if  in_ch ();
  imm_out_if out_ch ();

  assign out_ch.ready = rx_ready;

  integer_matrix_multiply u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // shadow of the block: element stores, written flags, dimension registers
  logic signed [DATA_WIDTH-1:0] mat_a [CELLS];
  logic signed [DATA_WIDTH-1:0] mat_b [CELLS];
  bit [CELLS-1:0]               wr_a;
  bit [CELLS-1:0]               wr_b;
  logic [DIM_W-1:0]             dim_reg [4];

  elem_t     product_q [$];
  plan_row_t plan [$];

  int fail_count;
  int results_seen;
  int hold_left;
  int rx_cycle;
  int n_items;
  bit held_once;
  bit tx_calm;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic int dim_used(logic [DIM_W-1:0] d);
    if (d == '0) return 1;
    if (d > DIM_W'(MAX_DIM)) return MAX_DIM;
    return int'(d);
  endfunction

  function automatic void predict_beat(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] r,
                                       logic [IDX_W-1:0] c,
                                       logic signed [DATA_WIDTH-1:0] v);
    int at;
    int ra;
    int ca;
    int rb;
    int cb;
    logic signed [DATA_WIDTH-1:0] acc;
    at = int'(r) * MAX_DIM + int'(c);
    ra = dim_used(dim_reg[REG_ROWS_A]);
    ca = dim_used(dim_reg[REG_COLS_A]);
    rb = dim_used(dim_reg[REG_ROWS_B]);
    cb = dim_used(dim_reg[REG_COLS_B]);
    case (cmd)
      CMD_LOAD_A: begin
        mat_a[at] = v;
        wr_a[at]  = 1'b1;
      end
      CMD_LOAD_B: begin
        mat_b[at] = v;
        wr_b[at]  = 1'b1;
      end
      CMD_MUL: begin
        if (ca != rb) begin
          product_q.push_back(elem_t'{r: '0, c: '0, product: '0, last: 1'b1,
                                      dim_error: 1'b1});
        end else begin
          for (int i = 0; i < ra; i++) begin
            for (int j = 0; j < cb; j++) begin
              acc = '0;
              for (int k = 0; k < ca; k++)
                acc = acc + mat_a[i*MAX_DIM+k] * mat_b[k*MAX_DIM+j];
              product_q.push_back(elem_t'{r: IDX_W'(i), c: IDX_W'(j), product: acc,
                                          last: (i == ra - 1 && j == cb - 1),
                                          dim_error: 1'b0});
            end
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void add_row(row_kind_t kind, logic [CFG_IDX_W-1:0] idx,
                                  logic [DIM_W-1:0] data, logic [CMD_W-1:0] cmd,
                                  logic [IDX_W-1:0] r, logic [IDX_W-1:0] c,
                                  logic signed [DATA_WIDTH-1:0] v, bit typed,
                                  logic signed [DATA_WIDTH-1:0] want, bit want_err);
    plan_row_t row;
    row.kind     = kind;
    row.idx      = idx;
    row.data     = data;
    row.cmd      = cmd;
    row.r        = r;
    row.c        = c;
    row.v        = v;
    row.typed    = typed;
    row.want     = want;
    row.want_err = want_err;
    plan.push_back(row);
  endfunction

  function automatic void add_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] data);
    add_row(ROW_REG, idx, data, CMD_NOP, '0, '0, '0, 1'b0, '0, 1'b0);
  endfunction

  function automatic void add_beat(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] r,
                                   logic [IDX_W-1:0] c, logic signed [DATA_WIDTH-1:0] v);
    add_row(ROW_BEAT, '0, '0, cmd, r, c, v, 1'b0, '0, 1'b0);
  endfunction

  // single-result multiply whose answer is known by inspection
  function automatic void add_mul(logic signed [DATA_WIDTH-1:0] want, bit want_err);
    add_row(ROW_BEAT, '0, '0, CMD_MUL, '0, '0, '0, 1'b1, want, want_err);
  endfunction

  function automatic void build_plan();
    add_reg(REG_ROWS_A, 4'd1);
    add_reg(REG_COLS_A, 4'd1);
    add_reg(REG_ROWS_B, 4'd1);
    add_reg(REG_COLS_B, 4'd1);
    // corners of the signed range, products wrap
    add_beat(CMD_LOAD_A, 3'd0, 3'd0, 32'sh7fffffff);
    add_beat(CMD_LOAD_B, 3'd0, 3'd0, 32'sh7fffffff);
    add_mul(32'sd1, 1'b0);
    add_beat(CMD_LOAD_A, 3'd0, 3'd0, 32'sh80000000);
    add_beat(CMD_LOAD_B, 3'd0, 3'd0, 32'sh80000000);
    add_mul(32'sd0, 1'b0);
    add_beat(CMD_LOAD_A, 3'd0, 3'd0, -32'sd1);
    add_mul(32'sh80000000, 1'b0);
    // unused command leaves the stores alone
    add_beat(CMD_NOP, 3'd7, 3'd7, 32'sh55aa55aa);
    add_mul(32'sh80000000, 1'b0);
    // kept although outside the current dimensions
    add_beat(CMD_LOAD_A, 3'd7, 3'd7, 32'sh12345678);
    add_beat(CMD_LOAD_B, 3'd7, 3'd7, 32'shfedcba98);
    add_reg(REG_COLS_A, 4'd2);
    add_reg(REG_ROWS_B, 4'd3);
    add_mul(32'sd0, 1'b1);
    // 15 clamps to 8, 0 counts as 1: still a mismatch
    add_reg(REG_COLS_A, 4'd15);
    add_reg(REG_ROWS_B, 4'd0);
    add_mul(32'sd0, 1'b1);
    add_reg(REG_ROWS_A, 4'd0);
    add_reg(REG_COLS_A, 4'd0);
    add_reg(REG_ROWS_B, 4'd1);
    add_reg(REG_COLS_B, 4'd0);
    add_mul(32'sh80000000, 1'b0);
    add_beat(CMD_LOAD_B, 3'd0, 3'd0, 32'sd0);
    add_mul(32'sd0, 1'b0);
    add_reg(REG_ROWS_A, 4'd2);
    add_reg(REG_COLS_A, 4'd2);
    add_reg(REG_ROWS_B, 4'd2);
    add_reg(REG_COLS_B, 4'd2);
    add_beat(CMD_LOAD_A, 3'd0, 3'd1, 32'sd3);
    add_beat(CMD_LOAD_A, 3'd1, 3'd0, -32'sd5);
    add_beat(CMD_LOAD_A, 3'd1, 3'd1, 32'sh40000000);
    add_beat(CMD_LOAD_B, 3'd0, 3'd1, 32'sd7);
    add_beat(CMD_LOAD_B, 3'd1, 3'd0, 32'sh7fffffff);
    add_beat(CMD_LOAD_B, 3'd1, 3'd1, -32'sd2);
    add_beat(CMD_MUL, 3'd5, 3'd2, 32'sd0);
    // loads keep knocking while the receiver holds off this multiply
    add_beat(CMD_LOAD_A, 3'd3, 3'd4, 32'sd11);
    add_beat(CMD_LOAD_B, 3'd4, 3'd3, -32'sd9);
    add_beat(CMD_LOAD_A, 3'd6, 3'd0, 32'sh0badcafe);
  endfunction

  function automatic logic [IDX_W-1:0] rand_idx();
    return IDX_W'($urandom_range(0, MAX_DIM - 1));
  endfunction

  function automatic logic signed [DATA_WIDTH-1:0] pick_value();
    case ($urandom_range(0, 11))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return -32'sd1;
      3: return 32'sd0;
      default: return $urandom();
    endcase
  endfunction

  // mostly small sizes, now and then 0, a size from 4 up to the largest, or beyond it
  function automatic logic [DIM_W-1:0] pick_dim();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 80) return DIM_W'($urandom_range(1, 3));
    if (roll < 88) return '0;
    if (roll < 94) return DIM_W'($urandom_range(9, 15));
    return DIM_W'($urandom_range(4, 8));
  endfunction

  task automatic offer_beat(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] r,
                            input logic [IDX_W-1:0] c,
                            input logic signed [DATA_WIDTH-1:0] v);
    while (!tx_calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.cmd   <= cmd;
    in_ch.row   <= r;
    in_ch.col   <= c;
    in_ch.value <= v;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic issue(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] r,
                       input logic [IDX_W-1:0] c, input logic signed [DATA_WIDTH-1:0] v);
    offer_beat(cmd, r, c, v);
    predict_beat(cmd, r, c, v);
    if (cmd != CMD_NOP) n_items++;
  endtask

  // cfg_we stays up when another write follows straight after
  task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] data,
                           input bit more);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    if (!more) cfg_we <= 1'b0;
    dim_reg[idx] = data;
  endtask

  task automatic wait_quiet();
    in_ch.valid <= 1'b0;
    while (product_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic random_load();
    issue($urandom_range(0, 1) ? CMD_LOAD_B : CMD_LOAD_A, rand_idx(), rand_idx(),
          pick_value());
  endtask

  // every entry the product reads gets written; some are refreshed anyway
  task automatic fill_operands(input int ra, input int ca, input int cb);
    int at;
    for (int i = 0; i < ra; i++) begin
      for (int k = 0; k < ca; k++) begin
        at = i * MAX_DIM + k;
        if (!wr_a[at] || $urandom_range(0, 3) == 0)
          issue(CMD_LOAD_A, IDX_W'(i), IDX_W'(k), pick_value());
      end
    end
    for (int k = 0; k < ca; k++) begin
      for (int j = 0; j < cb; j++) begin
        at = k * MAX_DIM + j;
        if (!wr_b[at] || $urandom_range(0, 3) == 0)
          issue(CMD_LOAD_B, IDX_W'(k), IDX_W'(j), pick_value());
      end
    end
  endtask

  task automatic run_phase(input int p);
    logic [DIM_W-1:0] d [4];
    int ra;
    int ca;
    int rb;
    int cb;
    wait_quiet();
    tx_calm = (p >= 2 && p < 8);
    if (p == 0) begin
      d = '{4'd15, 4'd1, 4'd1, 4'd9};
    end else if (p == 1) begin
      d = '{4'd1, 4'd9, 4'd8, 4'd1};
    end else begin
      d[0] = pick_dim();
      d[1] = pick_dim();
      d[2] = ($urandom_range(0, 99) < 85) ? d[1] : pick_dim();
      d[3] = pick_dim();
    end
    for (int i = 0; i < 4; i++) reg_write(CFG_IDX_W'(i), d[i], i < 3);
    ra = dim_used(d[0]);
    ca = dim_used(d[1]);
    rb = dim_used(d[2]);
    cb = dim_used(d[3]);
    repeat ($urandom_range(0, 3)) begin
      if ($urandom_range(0, 4) == 0) issue(CMD_NOP, rand_idx(), rand_idx(), pick_value());
      else random_load();
    end
    if (ca == rb) fill_operands(ra, ca, cb);
    issue(CMD_MUL, rand_idx(), rand_idx(), pick_value());
    if ($urandom_range(0, 99) < 15) begin
      random_load();
      issue(CMD_MUL, rand_idx(), rand_idx(), pick_value());
    end
    // beats queued behind a running multiply
    if (p == 0 || $urandom_range(0, 1) == 1)
      repeat ($urandom_range(1, 4)) random_load();
  endtask

  always @(posedge clk) begin
    elem_t got;
    elem_t exp_e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = elem_t'{r: out_ch.out_row, c: out_ch.out_col, product: out_ch.product,
                    last: out_ch.last, dim_error: out_ch.dim_error};
      results_seen++;
      if (product_q.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected beat: row %0d col %0d product %0d last %0b dim_error %0b",
                   got.r, got.c, got.product, got.last, got.dim_error);
      end else begin
        exp_e = product_q.pop_front();
        if (got.r !== exp_e.r || got.c !== exp_e.c || got.product !== exp_e.product ||
            got.last !== exp_e.last || got.dim_error !== exp_e.dim_error) begin
          fail_count++;
          if (fail_count <= 10)
            $display("mismatch: got %0d %0d %0d %0b %0b, expected %0d %0d %0d %0b %0b",
                     got.r, got.c, got.product, got.last, got.dim_error,
                     exp_e.r, exp_e.c, exp_e.product, exp_e.last, exp_e.dim_error);
        end
      end
      // hold off mid-multiply so the result slot and then the input back up
      if (!held_once && results_seen >= 8 && !got.last) begin
        held_once = 1'b1;
        hold_left = HOLD_CYCLES;
      end
    end
    rx_cycle++;
    if (hold_left > 0) begin
      hold_left--;
      rx_ready <= 1'b0;
    end else if (rx_cycle >= 700 && rx_cycle < 1300) begin
      rx_ready <= 1'b1;
    end else begin
      rx_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  initial begin
    rst_n       <= 1'b0;
    cfg_we      <= 1'b0;
    cfg_index   <= '0;
    cfg_data    <= '0;
    in_ch.valid <= 1'b0;
    in_ch.cmd   <= CMD_LOAD_A;
    in_ch.row   <= '0;
    in_ch.col   <= '0;
    in_ch.value <= '0;
    for (int i = 0; i < 4; i++) dim_reg[i] = DIM_W'(MAX_DIM);
    build_plan();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < plan.size(); i++) begin
      if (plan[i].kind == ROW_REG) begin
        if (i == 0 || plan[i-1].kind != ROW_REG) wait_quiet();
        reg_write(plan[i].idx, plan[i].data,
                  i + 1 < plan.size() && plan[i+1].kind == ROW_REG);
      end else begin
        offer_beat(plan[i].cmd, plan[i].r, plan[i].c, plan[i].v);
        if (plan[i].typed)
          product_q.push_back(elem_t'{r: '0, c: '0, product: plan[i].want, last: 1'b1,
                                      dim_error: plan[i].want_err});
        else
          predict_beat(plan[i].cmd, plan[i].r, plan[i].c, plan[i].v);
      end
    end

    n_items = 0;
    for (int p = 0; n_items < RANDOM_ITEMS; p++) run_phase(p);

    wait_quiet();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && product_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #(20_000_000);
    $display("Some tests failed");
    $finish;
  end

endmodule
